// File: rtl/sctf_pkg.sv
// ----------------------------------------------------------------------------
// sctf_pkg: shared types and constants of the serial character framer
// Phase codes, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package sctf_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned CountWidth = 8;
    localparam int unsigned DbcWidth   = 4;
    localparam int unsigned PauseWidth = 8;
    localparam int unsigned PhaseWidth = 3;
    localparam int unsigned CfgIdxWidth = 1;

    typedef logic [CharWidth-1:0]   char_t;
    typedef logic [CountWidth-1:0]  count_t;
    typedef logic [DbcWidth-1:0]    dbc_t;
    typedef logic [PauseWidth-1:0]  pause_t;
    typedef logic [PhaseWidth-1:0]  phase_t;
    typedef logic [CfgIdxWidth-1:0] cfg_idx_t;

    // Register indexes on the configuration port
    localparam cfg_idx_t REG_DATA_BIT_COUNT = 1'd0;
    localparam cfg_idx_t REG_PAUSE_LENGTH   = 1'd1;

    // Register reset values
    localparam dbc_t   DBC_RESET   = 4'd7;
    localparam pause_t PAUSE_RESET = 8'd25;

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Framer phases
    localparam phase_t PH_IDLE  = 3'd0;
    localparam phase_t PH_START = 3'd1;
    localparam phase_t PH_DATA  = 3'd2;
    localparam phase_t PH_STOPA = 3'd3;
    localparam phase_t PH_STOPB = 3'd4;
    localparam phase_t PH_PAUSE = 3'd5;

endpackage

// File: rtl/serial_char_tx_framer.sv
// ----------------------------------------------------------------------------
// serial_char_tx_framer: bit-tick serializer for a mark/space line
// Frames characters as space start bit, data bits LSB first, two mark stops.
// ----------------------------------------------------------------------------
// Usage: every input word is either a start command (loads next_char as the
// first character and arms the framer, no output word) or a bit tick (one
// output word carrying the line level for that tick). The frame is a space
// start bit, data_bit_count data bits LSB first (a count of zero sends one
// bit, bit positions above 7 go out as space), then two mark stop bits.
// During the second stop bit the offered next_char is taken: nonzero starts
// the next frame and raises char_taken, zero starts a mark pause of
// pause_length+1 ticks, after which the line idles at mark. A start command
// while a frame is running drops that frame. The block takes one word per
// clock while no result waits on out_ready: the word lands in an input
// register, one pass of phase/counter logic updates the framer state and
// fills the output register. A result waiting on out_ready holds the input
// register, so throughput is one word per cycle only while out_ready keeps
// the output slot draining. Configuration writes are always taken (cfg_ready
// is tied high) and must only be issued while the block is idle.
module serial_char_tx_framer
    import sctf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    // configuration write channel
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  cfg_idx_t cfg_index,
    input  pause_t   cfg_data,
    // input words
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     command,
    input  char_t    next_char,
    // output words
    output logic     out_valid,
    input  logic     out_ready,
    output logic     line_mark,
    output logic     char_taken,
    output logic     busy_res
);

    // configuration registers
    dbc_t   dbc_reg;
    pause_t pause_reg;

    // input register
    logic   s1_valid_reg;
    logic   s1_cmd_reg;
    char_t  s1_char_reg;

    // framer state
    phase_t phase_reg, phase_next;
    count_t step_reg, step_next;
    char_t  shift_reg, shift_next;

    // output register
    logic   out_valid_reg;
    logic   mark_reg, taken_reg, busy_reg;
    logic   mark_next, taken_next;

    logic   s1_advance;
    logic   out_load;
    count_t step_inc;

    assign cfg_ready = 1'b1;

    // Advance the input register when its word needs no output slot, or the
    // slot is free or draining this cycle.
    assign s1_advance = s1_valid_reg &&
                        ((s1_cmd_reg == CMD_START) || !out_valid_reg || out_ready);
    assign out_load   = s1_advance && (s1_cmd_reg == CMD_TICK);
    assign in_ready   = !s1_valid_reg || s1_advance;

    assign step_inc = step_reg + count_t'(1);

    // One tick of the framer
    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        mark_next  = 1'b1;
        taken_next = 1'b0;
        if (s1_cmd_reg == CMD_START)
        begin
            // drop any frame in progress and arm with the new character
            shift_next = s1_char_reg;
            phase_next = PH_START;
        end
        else
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    mark_next  = 1'b0;
                    phase_next = PH_DATA;
                    step_next  = '0;
                end
                PH_DATA:
                begin
                    // positions past the character go out as space
                    mark_next = (step_reg < count_t'(CharWidth)) ?
                                shift_reg[step_reg[2:0]] : 1'b0;
                    step_next = step_inc;
                    if (step_inc >= count_t'(dbc_reg))
                        phase_next = PH_STOPA;
                end
                PH_STOPA:
                begin
                    phase_next = PH_STOPB;
                end
                PH_STOPB:
                begin
                    shift_next = s1_char_reg;
                    if (s1_char_reg != '0)
                    begin
                        taken_next = 1'b1;
                        phase_next = PH_START;
                    end
                    else
                    begin
                        phase_next = PH_PAUSE;
                        step_next  = '0;
                    end
                end
                PH_PAUSE:
                begin
                    if (step_reg == count_t'(pause_reg))
                        phase_next = PH_IDLE;
                    else
                        step_next = step_inc;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbc_reg       <= DBC_RESET;
            pause_reg     <= PAUSE_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            step_reg      <= '0;
            shift_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_DATA_BIT_COUNT: dbc_reg   <= cfg_data[DbcWidth-1:0];
                    REG_PAUSE_LENGTH:   pause_reg <= cfg_data;
                    default:            pause_reg <= pause_reg;
                endcase
            end
            if (in_valid && in_ready)
                s1_valid_reg <= 1'b1;
            else if (s1_advance)
                s1_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (s1_advance)
            begin
                phase_reg <= phase_next;
                step_reg  <= step_next;
                shift_reg <= shift_next;
            end
        end
    end

    // Payload registers: hold the input word and the output word
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_cmd_reg  <= command;
            s1_char_reg <= next_char;
        end
        if (out_load)
        begin
            mark_reg  <= mark_next;
            taken_reg <= taken_next;
            busy_reg  <= (phase_next != PH_IDLE);
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_mark  = mark_reg;
    assign char_taken = taken_reg;
    assign busy_res   = busy_reg;

    // A character is only taken on a stop bit, with the framer still busy
    a_taken_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && taken_reg |-> mark_reg && busy_reg)
        else $error("char_taken outside a mark stop bit");

    // An idle result always shows mark
    a_idle_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !busy_reg |-> mark_reg)
        else $error("idle tick not at mark");

    // A start command arms the framer
    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && (s1_cmd_reg == CMD_START) |=> phase_reg == PH_START)
        else $error("start command did not arm the framer");

    // The tick after arming sends the space start bit
    a_start_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (phase_reg == PH_START) |=> out_valid_reg && !mark_reg)
        else $error("start bit not sent as space");

    // The data bit index never runs past the widest count
    a_data_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> step_reg < count_t'(16))
        else $error("data bit index out of range");

endmodule
